FILE: rtl/fbp_pkg.sv
// shared constants, payload types and helpers of the framebuffer blend plotter
package fbp_pkg;

	localparam int ROW_COUNT = 256;
	localparam int COL_COUNT = 256;
	localparam int FRAC_BITS = 8;

	localparam int COORD_W = 16;
	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int RND_W   = COORD_W - FRAC_BITS + 1;
	localparam int ROW_W   = $clog2(ROW_COUNT);
	localparam int COL_W   = $clog2(COL_COUNT);
	localparam int DEPTH   = ROW_COUNT * COL_COUNT;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PROD_W  = 2 * CH_W + 1;

	localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((32'd1 << FRAC_BITS) - 32'd1);
	localparam logic [COORD_W-1:0] HALF      = COORD_W'(32'd1 << (FRAC_BITS - 1));
	localparam logic [CH_W-1:0]    CH_MAX    = 8'd255;
	localparam logic [CH_W-1:0]    CH_MID    = 8'd128;

	localparam logic REQ_PLOT     = 1'b0;
	localparam logic REQ_READ     = 1'b1;
	localparam logic MODE_OVERLAY = 1'b0;
	localparam logic MODE_LIGHTEN = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] row_pos;
		logic [COORD_W-1:0] col_pos;
		logic [CH_W-1:0]    red_in;
		logic [CH_W-1:0]    green_in;
		logic [CH_W-1:0]    blue_in;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            out_of_range;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_WRITE
	} state_t;

	// fraction above one half rounds up, one half and below rounds down
	function automatic logic [RND_W-1:0] round_coord(input logic [COORD_W-1:0] pos);
		logic [COORD_W-1:0] whole;
		logic [COORD_W-1:0] frac;
		whole = pos >> FRAC_BITS;
		frac  = pos & FRAC_MASK;
		return RND_W'({1'b0, whole} + ((frac > HALF) ? 17'd1 : 17'd0));
	endfunction

	// exact x / 255 for x below 255 * 256
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W-1:0] sum;
		sum = x + (x >> 8) + PROD_W'(1);
		return sum[15:8];
	endfunction

endpackage

FILE: rtl/fbp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module fbp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/framebuffer_blend_plot.sv
// top level of the framebuffer plotter with overlay and lighten blending
// each accepted word steps through the read, multiply and divide/write states before its result is registered
// a new word is taken only once the read-modify-write sequence on the frame ram is back in idle
// a busy result register holds the sequence in its write step until the result is taken
// reset: after arst_n the frame ram is zeroed one pixel a cycle, all ROW_COUNT*COL_COUNT
// (65536) pixels, with req_ready low; blend_mode resets to overlay
module framebuffer_blend_plot (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            req_valid,
	output logic            req_ready,
	input  fbp_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output fbp_pkg::rsp_t   rsp
);

	fbp_pkg::state_t state_q, state_d;

	logic                         blend_mode_q;
	logic [fbp_pkg::ADDR_W-1:0]   clr_q;
	logic                         is_read_q;
	logic                         oor_q;
	logic [fbp_pkg::ROW_W-1:0]    row_q;
	logic [fbp_pkg::COL_W-1:0]    col_q;
	logic [fbp_pkg::PIX_W-1:0]    color_q;
	logic [fbp_pkg::ADDR_W-1:0]   addr_q;
	logic [fbp_pkg::PIX_W-1:0]    pix_q;
	logic [fbp_pkg::PROD_W-1:0]   prod_q [3];
	logic [2:0]                   hi_q;
	logic [fbp_pkg::CH_W-1:0]     lite_q [3];
	logic                         rsp_valid_q;
	fbp_pkg::rsp_t                rsp_q;

	logic [fbp_pkg::RND_W-1:0]    rnd_row;
	logic [fbp_pkg::RND_W-1:0]    rnd_col;
	logic                         rnd_oor;
	logic [fbp_pkg::ADDR_W-1:0]   rd_addr;
	logic [fbp_pkg::PIX_W-1:0]    rd_data;
	logic                         rd_en;
	logic                         wr_en;
	logic [fbp_pkg::ADDR_W-1:0]   wr_addr;
	logic [fbp_pkg::PIX_W-1:0]    wr_data;
	logic [fbp_pkg::PIX_W-1:0]    blend_pix;
	logic [fbp_pkg::CH_W-1:0]     mul_a [3];
	logic [fbp_pkg::CH_W-1:0]     mul_b [3];
	logic                         accept;
	logic                         advance;
	logic                         clear_step;
	fbp_pkg::rsp_t                rsp_d;

	assign accept  = req_valid && req_ready;
	assign advance = !rsp_valid_q || rsp_ready;

	assign rnd_row = fbp_pkg::round_coord(req.row_pos);
	assign rnd_col = fbp_pkg::round_coord(req.col_pos);
	assign rnd_oor = (32'(rnd_row) >= 32'(fbp_pkg::ROW_COUNT))
		|| (32'(rnd_col) >= 32'(fbp_pkg::COL_COUNT));

	assign rd_addr = fbp_pkg::ADDR_W'(32'(row_q) * 32'(fbp_pkg::COL_COUNT) + 32'(col_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbp_pkg::ST_CLEAR: begin
				if (clr_q == fbp_pkg::LAST_ADDR) begin
					state_d = fbp_pkg::ST_IDLE;
				end
			end
			fbp_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = fbp_pkg::ST_READ;
				end
			end
			fbp_pkg::ST_READ:  state_d = fbp_pkg::ST_MUL;
			fbp_pkg::ST_MUL:   state_d = fbp_pkg::ST_WRITE;
			fbp_pkg::ST_WRITE: begin
				if (advance) begin
					state_d = fbp_pkg::ST_IDLE;
				end
			end
			default: state_d = fbp_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready  = 1'b0;
		rd_en      = 1'b0;
		clear_step = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = blend_pix;
		case (state_q)
			fbp_pkg::ST_CLEAR: begin
				clear_step = 1'b1;
				wr_en      = 1'b1;
				wr_addr    = clr_q;
				wr_data    = '0;
			end
			fbp_pkg::ST_IDLE:  req_ready = 1'b1;
			fbp_pkg::ST_READ:  rd_en = !oor_q;
			fbp_pkg::ST_MUL:   ;
			fbp_pkg::ST_WRITE: wr_en = advance && !oor_q && (is_read_q == fbp_pkg::REQ_PLOT);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbp_pkg::ST_CLEAR;
			clr_q        <= '0;
			blend_mode_q <= fbp_pkg::MODE_OVERLAY;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_step) begin
				clr_q <= clr_q + fbp_pkg::ADDR_W'(1);
			end
			if (cfg_wr_en) begin
				blend_mode_q <= cfg_wr_data;
			end
			if (state_q == fbp_pkg::ST_WRITE && advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	fbp_ram #(
		.WIDTH (fbp_pkg::PIX_W),
		.DEPTH (fbp_pkg::DEPTH)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// overlay operands: dark half uses s and c, bright half their complements
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W] < fbp_pkg::CH_MID) begin
				mul_a[i] = rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W];
				mul_b[i] = color_q[i*fbp_pkg::CH_W +: fbp_pkg::CH_W];
			end else begin
				mul_a[i] = fbp_pkg::CH_MAX - rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W];
				mul_b[i] = fbp_pkg::CH_MAX - color_q[i*fbp_pkg::CH_W +: fbp_pkg::CH_W];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (blend_mode_q == fbp_pkg::MODE_LIGHTEN) begin
				blend_pix[i*fbp_pkg::CH_W +: fbp_pkg::CH_W] = lite_q[i];
			end else if (hi_q[i]) begin
				blend_pix[i*fbp_pkg::CH_W +: fbp_pkg::CH_W] =
					fbp_pkg::CH_MAX - fbp_pkg::div255(prod_q[i]);
			end else begin
				blend_pix[i*fbp_pkg::CH_W +: fbp_pkg::CH_W] = fbp_pkg::div255(prod_q[i]);
			end
		end
	end

	always_comb begin
		if (oor_q) begin
			rsp_d = '{red_out: '0, green_out: '0, blue_out: '0, out_of_range: 1'b1};
		end else if (is_read_q == fbp_pkg::REQ_READ) begin
			rsp_d = '{red_out: pix_q[23:16], green_out: pix_q[15:8],
				blue_out: pix_q[7:0], out_of_range: 1'b0};
		end else begin
			rsp_d = '{red_out: blend_pix[23:16], green_out: blend_pix[15:8],
				blue_out: blend_pix[7:0], out_of_range: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_q <= req.req_type;
			oor_q     <= rnd_oor;
			row_q     <= fbp_pkg::ROW_W'(32'(rnd_row));
			col_q     <= fbp_pkg::COL_W'(32'(rnd_col));
			color_q   <= {req.red_in, req.green_in, req.blue_in};
		end
		if (state_q == fbp_pkg::ST_READ) begin
			addr_q <= rd_addr;
		end
		if (state_q == fbp_pkg::ST_MUL) begin
			pix_q <= rd_data;
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= {16'(mul_a[i]) * 16'(mul_b[i]), 1'b0};
				hi_q[i]   <= rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W] >= fbp_pkg::CH_MID;
				lite_q[i] <= (rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W]
					< color_q[i*fbp_pkg::CH_W +: fbp_pkg::CH_W])
					? color_q[i*fbp_pkg::CH_W +: fbp_pkg::CH_W]
					: rd_data[i*fbp_pkg::CH_W +: fbp_pkg::CH_W];
			end
		end
		if (state_q == fbp_pkg::ST_WRITE && advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == fbp_pkg::ST_READ)
		else $error("accepted word did not start a read");

	a_write_only_plot: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != fbp_pkg::ST_CLEAR)
		|-> (!oor_q && is_read_q == fbp_pkg::REQ_PLOT && state_q == fbp_pkg::ST_WRITE))
		else $error("frame write outside an in-range plot");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbp_pkg::ST_WRITE && rsp_valid_q && !rsp_ready)
		|=> state_q == fbp_pkg::ST_WRITE)
		else $error("result overwritten while held");

	a_oor_black: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_of_range)
		|-> (rsp.red_out == '0 && rsp.green_out == '0 && rsp.blue_out == '0))
		else $error("out of range result carries color");

	a_clear_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbp_pkg::ST_CLEAR) |-> (!req_ready && !rsp_valid_q))
		else $error("activity during clearing pass");

endmodule
